/* rtl/core/sgm_pkg.sv */
// ----------------------------------------------------------------------------
// sgm_pkg
// Shared widths, register indexes and control types of the Sobel gradient
// magnitude block.
// ----------------------------------------------------------------------------
package sgm_pkg;

  localparam int PIXEL_W           = 8;
  localparam int GRAD_W            = 11;
  localparam int DIM_W             = 13;
  localparam int CFG_INDEX_W       = 4;
  localparam int CFG_DATA_W        = 13;
  localparam int LINE_W            = 2 * PIXEL_W;
  localparam int MAX_WIDTH_DEFAULT = 4096;
  localparam int HEIGHT_LIMIT      = 4096;
  localparam int WIDTH_RESET       = 512;
  localparam int HEIGHT_RESET      = 512;

  localparam logic [CFG_INDEX_W-1:0] REG_FRAME_WIDTH  = 4'd0;
  localparam logic [CFG_INDEX_W-1:0] REG_FRAME_HEIGHT = 4'd1;

  localparam logic OP_PIXEL = 1'b0;

  typedef struct packed {
    logic step;
    logic use_old;
    logic zero_top;
    logic zero_bottom;
    logic zero_left;
  } win_ctrl_t;

  typedef struct packed {
    logic [PIXEL_W-1:0] top;
    logic [PIXEL_W-1:0] mid;
    logic [PIXEL_W-1:0] bot;
  } win_col_t;

  typedef struct packed {
    logic               done;
    logic [PIXEL_W-1:0] magnitude;
  } mag_status_t;

endpackage

/* rtl/core/sgm_ifs.sv */
// ----------------------------------------------------------------------------
// Sobel gradient magnitude channels
// Valid/ready channels for pixels, results and register writes.
// ----------------------------------------------------------------------------
interface sgm_pixel_if;
  logic                        valid;
  logic                        ready;
  logic                        operation;
  logic [sgm_pkg::PIXEL_W-1:0] pixel;

  modport source (output valid, operation, pixel, input ready);
  modport sink   (input valid, operation, pixel, output ready);
endinterface

interface sgm_result_if;
  logic                        valid;
  logic                        ready;
  logic [sgm_pkg::PIXEL_W-1:0] magnitude;
  logic                        row_end;
  logic                        frame_end;

  modport source (output valid, magnitude, row_end, frame_end, input ready);
  modport sink   (input valid, magnitude, row_end, frame_end, output ready);
endinterface

interface sgm_cfg_if;
  logic                            valid;
  logic                            ready;
  logic [sgm_pkg::CFG_INDEX_W-1:0] index;
  logic [sgm_pkg::CFG_DATA_W-1:0]  data;

  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

/* rtl/core/sgm_ram.sv */
// ----------------------------------------------------------------------------
// sgm_ram
// Generic simple dual-port RAM, one write and one registered read port.
// ----------------------------------------------------------------------------
module sgm_ram #(
  parameter int WIDTH = sgm_pkg::LINE_W,
  parameter int DEPTH = sgm_pkg::MAX_WIDTH_DEFAULT
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

/* rtl/core/sgm_window.sv */
// ----------------------------------------------------------------------------
// sgm_window
// 3x3 pixel window with border padding and registered Sobel X/Y gradients.
// ----------------------------------------------------------------------------
module sgm_window (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  sgm_pkg::win_ctrl_t                   ctrl_i,
  input  sgm_pkg::win_col_t                    col_i,
  output logic signed [sgm_pkg::GRAD_W-1:0]    gx_o,
  output logic signed [sgm_pkg::GRAD_W-1:0]    gy_o
);

  logic [2:0][2:0][sgm_pkg::PIXEL_W-1:0] win_q, win_d;
  logic [2:0][2:0][sgm_pkg::PIXEL_W-1:0] nb;
  logic signed [sgm_pkg::GRAD_W-1:0]     p [3][3];
  logic signed [sgm_pkg::GRAD_W-1:0]     gx_d, gy_d, gx_q, gy_q;

  always_comb begin
    win_d = win_q;
    if (ctrl_i.step) begin
      for (int i = 0; i < 3; i++) begin
        win_d[i][0] = win_q[i][1];
        win_d[i][1] = win_q[i][2];
      end
      win_d[0][2] = col_i.top;
      win_d[1][2] = col_i.mid;
      win_d[2][2] = col_i.bot;
    end
  end

  always_comb begin
    if (ctrl_i.use_old) begin
      for (int i = 0; i < 3; i++) begin
        nb[i][0] = win_q[i][1];
        nb[i][1] = win_q[i][2];
        nb[i][2] = '0;
      end
    end else begin
      nb = win_d;
    end
    if (ctrl_i.zero_top) begin
      nb[0] = '0;
    end
    if (ctrl_i.zero_bottom) begin
      nb[2] = '0;
    end
    if (ctrl_i.zero_left) begin
      for (int i = 0; i < 3; i++) begin
        nb[i][0] = '0;
      end
    end
  end

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      for (int j = 0; j < 3; j++) begin
        p[i][j] = $signed(sgm_pkg::GRAD_W'(nb[i][j]));
      end
    end
    gx_d = (p[0][2] - p[0][0]) + ((p[1][2] - p[1][0]) <<< 1) + (p[2][2] - p[2][0]);
    gy_d = (p[2][0] - p[0][0]) + ((p[2][1] - p[0][1]) <<< 1) + (p[2][2] - p[0][2]);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      win_q <= '0;
    end else begin
      win_q <= win_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctrl_i.step) begin
      gx_q <= gx_d;
      gy_q <= gy_d;
    end
  end

  assign gx_o = gx_q;
  assign gy_o = gy_q;

endmodule

/* rtl/core/sgm_isqrt.sv */
// ----------------------------------------------------------------------------
// sgm_isqrt
// Iterative magnitude unit: sum of squares, then one root bit per cycle,
// saturating at full scale.
// ----------------------------------------------------------------------------
module sgm_isqrt (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              start_i,
  input  logic signed [sgm_pkg::GRAD_W-1:0] gx_i,
  input  logic signed [sgm_pkg::GRAD_W-1:0] gy_i,
  output sgm_pkg::mag_status_t              status_o
);

  localparam int ABS_W   = sgm_pkg::GRAD_W - 1;
  localparam int SQ_W    = 2 * ABS_W;
  localparam int SUMSQ_W = SQ_W + 1;
  localparam int ROOT_W  = sgm_pkg::PIXEL_W;
  localparam int IDX_W   = $clog2(ROOT_W);

  typedef enum logic [1:0] {
    IS_IDLE = 2'b01,
    IS_ITER = 2'b10
  } is_state_e;

  is_state_e            state_q, state_d;
  logic                 done_q, done_d;
  logic [IDX_W-1:0]     idx_q, idx_d;
  logic [ROOT_W-1:0]    root_q, root_d;
  logic [SUMSQ_W-1:0]   s_q, s_d;
  logic [ABS_W-1:0]     ax, ay;
  logic [SQ_W-1:0]      ax2, ay2;
  logic [ROOT_W-1:0]    trial;
  logic [2*ROOT_W-1:0]  trial2;
  logic                 sat;

  assign ax     = ABS_W'(gx_i[sgm_pkg::GRAD_W-1] ? -gx_i : gx_i);
  assign ay     = ABS_W'(gy_i[sgm_pkg::GRAD_W-1] ? -gy_i : gy_i);
  assign ax2    = ax * ax;
  assign ay2    = ay * ay;
  assign trial  = root_q | (ROOT_W'(1) << idx_q);
  assign trial2 = trial * trial;
  assign sat    = |s_q[SUMSQ_W-1:2*ROOT_W];

  always_comb begin
    state_d = state_q;
    done_d  = 1'b0;
    idx_d   = idx_q;
    root_d  = root_q;
    s_d     = s_q;
    unique case (state_q)
      IS_IDLE: begin
        if (start_i) begin
          s_d     = SUMSQ_W'(ax2) + SUMSQ_W'(ay2);
          root_d  = '0;
          idx_d   = IDX_W'(ROOT_W - 1);
          state_d = IS_ITER;
        end
      end
      IS_ITER: begin
        if (sat) begin
          root_d  = '1;
          done_d  = 1'b1;
          state_d = IS_IDLE;
        end else begin
          if (trial2 <= s_q[2*ROOT_W-1:0]) begin
            root_d = trial;
          end
          if (idx_q == '0) begin
            done_d  = 1'b1;
            state_d = IS_IDLE;
          end else begin
            idx_d = idx_q - IDX_W'(1);
          end
        end
      end
      default: begin
        state_d = IS_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= IS_IDLE;
      done_q  <= 1'b0;
      idx_q   <= '0;
    end else begin
      state_q <= state_d;
      done_q  <= done_d;
      idx_q   <= idx_d;
    end
  end

  always_ff @(posedge clk_i) begin
    root_q <= root_d;
    s_q    <= s_d;
  end

  assign status_o.done      = done_q;
  assign status_o.magnitude = root_q;

endmodule

/* rtl/core/sobel_gradient_magnitude_top.sv */
// ----------------------------------------------------------------------------
// sobel_gradient_magnitude_top
// Streaming 3x3 Sobel edge magnitude over raster-order grey pixels.
// ----------------------------------------------------------------------------
// Pixels arrive in raster order, one transfer per item; each frame is followed
// by frame_width+1 flush items, and the result for a pixel leaves one row and
// one pixel later, zero padded at the borders and saturated at 255. Items are
// handled one at a time: an item without a result goes through a line
// store read, then write-back and window shift; one with a result also
// waits for the magnitude unit, which resolves one root bit per cycle and
// finishes early when the sum of squares saturates. The result register
// lets the next pixel be taken while a result waits. Both line stores
// share one RAM of MAX_WIDTH words, each holding the two previous rows'
// pixels of a column. Width/height writes restart the frame counters.
// ----------------------------------------------------------------------------
module sobel_gradient_magnitude_top #(
  parameter int MAX_WIDTH = sgm_pkg::MAX_WIDTH_DEFAULT
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  sgm_pixel_if.sink     pix_i,
  sgm_result_if.source  res_o,
  sgm_cfg_if.sink       cfg_i
);

  localparam int CW    = $clog2(MAX_WIDTH);
  localparam int WW    = CW + 1;
  localparam int DIM_W = sgm_pkg::DIM_W;
  localparam int PW    = sgm_pkg::PIXEL_W;

  typedef enum logic [4:0] {
    ST_IDLE = 5'b00001,
    ST_READ = 5'b00010,
    ST_GRAD = 5'b00100,
    ST_MAG  = 5'b01000,
    ST_HOLD = 5'b10000
  } state_e;

  typedef struct packed {
    logic emit;
    logic use_old;
    logic zero_top;
    logic zero_bottom;
    logic zero_left;
    logic frame_end;
  } item_t;

  state_e                state_q, state_d;
  logic [DIM_W-1:0]      width_q, width_d, height_q, height_d;
  logic [CW-1:0]         col_q, col_d;
  logic [DIM_W-1:0]      row_q, row_d;
  logic [WW-1:0]         eff_w;
  logic [DIM_W-1:0]      eff_h, eff_h1;
  logic [CW-1:0]         c_eff;
  logic [WW-1:0]         c_inc;
  logic                  c_zero;
  logic [PW-1:0]         v;
  item_t                 item_q, item_d;
  logic [CW-1:0]         addr_q;
  logic [PW-1:0]         pix_q;
  logic                  pix_fire, cfg_fire, cfg_hit;
  logic [sgm_pkg::LINE_W-1:0] ram_rdata;
  sgm_pkg::win_ctrl_t    win_ctrl;
  sgm_pkg::win_col_t     win_col;
  logic signed [sgm_pkg::GRAD_W-1:0] gx, gy;
  sgm_pkg::mag_status_t  mag;
  logic                  out_free, load;
  logic                  res_valid_q, res_valid_d;
  logic [PW-1:0]         mag_q;
  logic                  row_end_q, frame_end_q;

  always_comb begin
    if (width_q == '0) begin
      eff_w = WW'(1);
    end else if (32'(width_q) > MAX_WIDTH) begin
      eff_w = WW'(MAX_WIDTH);
    end else begin
      eff_w = WW'(width_q);
    end
    if (height_q == '0) begin
      eff_h = DIM_W'(1);
    end else if (32'(height_q) > sgm_pkg::HEIGHT_LIMIT) begin
      eff_h = DIM_W'(sgm_pkg::HEIGHT_LIMIT);
    end else begin
      eff_h = height_q;
    end
  end

  assign eff_h1   = eff_h + DIM_W'(1);
  assign c_eff    = ({1'b0, col_q} >= eff_w) ? '0 : col_q;
  assign c_inc    = {1'b0, c_eff} + WW'(1);
  assign c_zero   = (c_eff == '0);
  assign pix_fire = pix_i.valid & pix_i.ready;
  assign cfg_fire = cfg_i.valid & cfg_i.ready;
  assign v        = (pix_i.operation == sgm_pkg::OP_PIXEL && row_q < eff_h) ? pix_i.pixel : '0;

  assign pix_i.ready = (state_q == ST_IDLE);
  assign cfg_i.ready = 1'b1;

  always_comb begin
    item_d.emit        = (row_q >= DIM_W'(2)) || (row_q == DIM_W'(1) && !c_zero);
    item_d.use_old     = c_zero;
    item_d.zero_top    = c_zero ? (row_q == DIM_W'(2)) : (row_q == DIM_W'(1));
    item_d.zero_bottom = c_zero ? (row_q == eff_h1) : (row_q == eff_h);
    item_d.zero_left   = (c_eff == CW'(1)) || (c_zero && eff_w == WW'(1));
    item_d.frame_end   = c_zero && (row_q == eff_h1);
  end

  always_comb begin
    width_d  = width_q;
    height_d = height_q;
    cfg_hit  = 1'b0;
    if (cfg_fire) begin
      unique case (cfg_i.index)
        sgm_pkg::REG_FRAME_WIDTH: begin
          width_d = cfg_i.data;
          cfg_hit = 1'b1;
        end
        sgm_pkg::REG_FRAME_HEIGHT: begin
          height_d = cfg_i.data;
          cfg_hit  = 1'b1;
        end
        default: begin
        end
      endcase
    end
  end

  always_comb begin
    col_d = col_q;
    row_d = row_q;
    if (cfg_hit) begin
      col_d = '0;
      row_d = '0;
    end else if (pix_fire) begin
      if (row_q > eff_h) begin
        col_d = '0;
        row_d = '0;
      end else if (c_inc >= eff_w) begin
        col_d = '0;
        row_d = row_q + DIM_W'(1);
      end else begin
        col_d = c_inc[CW-1:0];
      end
    end
  end

  sgm_ram #(
    .WIDTH (sgm_pkg::LINE_W),
    .DEPTH (MAX_WIDTH)
  ) u_line_ram (
    .clk_i   (clk_i),
    .we_i    (state_q == ST_READ),
    .waddr_i (addr_q),
    .wdata_i ({ram_rdata[PW-1:0], pix_q}),
    .re_i    (pix_fire),
    .raddr_i (c_eff),
    .rdata_o (ram_rdata)
  );

  assign win_ctrl.step        = (state_q == ST_READ);
  assign win_ctrl.use_old     = item_q.use_old;
  assign win_ctrl.zero_top    = item_q.zero_top;
  assign win_ctrl.zero_bottom = item_q.zero_bottom;
  assign win_ctrl.zero_left   = item_q.zero_left;
  assign win_col.top          = ram_rdata[2*PW-1:PW];
  assign win_col.mid          = ram_rdata[PW-1:0];
  assign win_col.bot          = pix_q;

  sgm_window u_window (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .ctrl_i (win_ctrl),
    .col_i  (win_col),
    .gx_o   (gx),
    .gy_o   (gy)
  );

  sgm_isqrt u_isqrt (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .start_i  (state_q == ST_GRAD),
    .gx_i     (gx),
    .gy_i     (gy),
    .status_o (mag)
  );

  assign out_free = !res_valid_q || res_o.ready;

  always_comb begin
    state_d = state_q;
    load    = 1'b0;
    unique case (state_q)
      ST_IDLE: begin
        if (pix_fire) begin
          state_d = ST_READ;
        end
      end
      ST_READ: begin
        state_d = item_q.emit ? ST_GRAD : ST_IDLE;
      end
      ST_GRAD: begin
        state_d = ST_MAG;
      end
      ST_MAG: begin
        if (mag.done) begin
          if (out_free) begin
            load    = 1'b1;
            state_d = ST_IDLE;
          end else begin
            state_d = ST_HOLD;
          end
        end
      end
      ST_HOLD: begin
        if (out_free) begin
          load    = 1'b1;
          state_d = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_comb begin
    res_valid_d = res_valid_q;
    if (load) begin
      res_valid_d = 1'b1;
    end else if (res_o.ready) begin
      res_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      width_q     <= DIM_W'(sgm_pkg::WIDTH_RESET);
      height_q    <= DIM_W'(sgm_pkg::HEIGHT_RESET);
      col_q       <= '0;
      row_q       <= '0;
      item_q      <= '0;
      res_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      width_q     <= width_d;
      height_q    <= height_d;
      col_q       <= col_d;
      row_q       <= row_d;
      res_valid_q <= res_valid_d;
      if (pix_fire) begin
        item_q <= item_d;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (pix_fire) begin
      addr_q <= c_eff;
      pix_q  <= v;
    end
    if (load) begin
      mag_q       <= mag.magnitude;
      row_end_q   <= item_q.use_old;
      frame_end_q <= item_q.frame_end;
    end
  end

  assign res_o.valid     = res_valid_q;
  assign res_o.magnitude = mag_q;
  assign res_o.row_end   = row_end_q;
  assign res_o.frame_end = frame_end_q;

  a_done_in_mag : assert property (@(posedge clk_i) disable iff (!rst_ni)
    mag.done |-> state_q == ST_MAG)
    else $error("magnitude unit finished outside the wait state");

  a_col_in_range : assert property (@(posedge clk_i) disable iff (!rst_ni)
    {1'b0, col_q} < eff_w)
    else $error("column counter beyond frame width");

  a_row_in_range : assert property (@(posedge clk_i) disable iff (!rst_ni)
    row_q <= eff_h1)
    else $error("row counter beyond flush row");

  a_frame_end_row : assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_o.valid && res_o.frame_end |-> res_o.row_end)
    else $error("frame end without row end");

endmodule
